### design/track_phase_pd_steering_top_assert.svh
// Assertion macros shared by the track-phase steering modules
`ifndef TRACK_PHASE_PD_STEERING_TOP_ASSERT_SVH
`define TRACK_PHASE_PD_STEERING_TOP_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define TPPS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tpps assertion failed");

// next-cycle implication
`define TPPS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tpps assertion failed");

`endif

### design/tpps_pkg.sv
// Types, constants and phase tables for the track-phase steering block
`default_nettype none
package tpps_pkg;

   localparam int POS_BITS   = 12;
   localparam int COUNT_BITS = 10;
   localparam int SIGHT_BITS = 8;
   localparam int PHASE_BITS = 3;
   localparam int MARK_BITS  = 2;
   localparam int DUTY_BITS  = 7;
   localparam int ANGLE_BITS = 16;
   localparam int GP_BITS    = 11;
   localparam int GD_BITS    = 18;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = COUNT_BITS;

   localparam logic [PHASE_BITS-1:0] PH_CORNER_ENTRY = 3'd0;
   localparam logic [PHASE_BITS-1:0] PH_CORNER       = 3'd1;
   localparam logic [PHASE_BITS-1:0] PH_FAST_ENTRY   = 3'd2;
   localparam logic [PHASE_BITS-1:0] PH_FAST         = 3'd3;
   localparam logic [PHASE_BITS-1:0] PH_BRAKE_ENTRY  = 3'd4;
   localparam logic [PHASE_BITS-1:0] PH_BRAKE        = 3'd5;

   localparam logic [MARK_BITS-1:0] MARK_NONE   = 2'd0;
   localparam logic [MARK_BITS-1:0] MARK_TRIPLE = 2'd1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_QUALIFY      = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FAST_ENTRY   = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BRAKE_ENTRY  = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CORNER_ENTRY = 2'd3;

   localparam logic [SIGHT_BITS-1:0] QUALIFY_RESET      = 8'd6;
   localparam logic [COUNT_BITS-1:0] FAST_ENTRY_RESET   = COUNT_BITS'(100);
   localparam logic [COUNT_BITS-1:0] BRAKE_ENTRY_RESET  = COUNT_BITS'(130);
   localparam logic [COUNT_BITS-1:0] CORNER_ENTRY_RESET = COUNT_BITS'(10);

   typedef struct packed {
      logic signed [POS_BITS-1:0] line_position;
      logic [MARK_BITS-1:0]       road_mark;
      logic                       remote_enable;
   } req_type;

   typedef struct packed {
      logic signed [ANGLE_BITS-1:0] steer_angle;
      logic [DUTY_BITS-1:0]         motor_duty;
      logic                         motor_update;
      logic [PHASE_BITS-1:0]        phase;
   } rsp_type;

   typedef struct packed {
      logic [SIGHT_BITS-1:0] qualify_threshold;
      logic [COUNT_BITS-1:0] fast_entry_ticks;
      logic [COUNT_BITS-1:0] brake_entry_ticks;
      logic [COUNT_BITS-1:0] corner_entry_ticks;
   } cfg_type;

   typedef struct packed {
      logic [PHASE_BITS-1:0]      phase;
      logic                       enable;
      logic signed [POS_BITS-1:0] pos;
      logic signed [POS_BITS:0]   diff;
   } s1_type;

   // proportional gain, Q16 with 0.75 folded in
   function automatic logic [GP_BITS-1:0] gain_p(input logic [PHASE_BITS-1:0] ph);
      case (ph)
         PH_FAST_ENTRY, PH_FAST, PH_BRAKE_ENTRY, PH_BRAKE: gain_p = GP_BITS'(492);
         default:                                          gain_p = GP_BITS'(1229);
      endcase
   endfunction

   // derivative gain, Q16 with 0.75 folded in
   function automatic logic [GD_BITS-1:0] gain_d(input logic [PHASE_BITS-1:0] ph);
      case (ph)
         PH_FAST:                                   gain_d = GD_BITS'(6881);
         PH_FAST_ENTRY, PH_BRAKE_ENTRY, PH_BRAKE:   gain_d = GD_BITS'(4915);
         default:                                   gain_d = GD_BITS'(180879);
      endcase
   endfunction

   function automatic logic [DUTY_BITS-1:0] phase_duty(input logic [PHASE_BITS-1:0] ph);
      case (ph)
         PH_FAST_ENTRY:  phase_duty = DUTY_BITS'(27);
         PH_FAST:        phase_duty = DUTY_BITS'(35);
         PH_BRAKE_ENTRY: phase_duty = DUTY_BITS'(20);
         PH_BRAKE:       phase_duty = DUTY_BITS'(5);
         default:        phase_duty = DUTY_BITS'(19);
      endcase
   endfunction

endpackage
`default_nettype wire

### design/tpps_seq.sv
// Six-phase track sequencer: mark qualification and entry countdowns
`default_nettype none
`include "track_phase_pd_steering_top_assert.svh"
module tpps_seq
   import tpps_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire logic [MARK_BITS-1:0]  road_mark,
   input  wire cfg_type               cfg,
   output logic [PHASE_BITS-1:0]      phase_next
);

   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic [SIGHT_BITS-1:0] count_ff, count_in;
   logic [SIGHT_BITS-1:0] count_sight;
   logic                  seen;
   logic                  qualify;
   logic                  cd_done;

   always_comb begin
      seen        = (phase_ff == PH_BRAKE) ? (road_mark == MARK_NONE)
                                           : (road_mark == MARK_TRIPLE);
      count_sight = !seen ? '0 :
                    (&count_ff) ? count_ff : count_ff + SIGHT_BITS'(1);
      qualify     = count_sight > cfg.qualify_threshold;
      cd_done     = (cnt_ff == '0);
      phase_in    = phase_ff;
      cnt_in      = cnt_ff;
      count_in    = count_ff;
      case (phase_ff)
         PH_CORNER_ENTRY, PH_FAST_ENTRY, PH_BRAKE_ENTRY: begin
            cnt_in = cnt_ff - COUNT_BITS'(1);
            if (cd_done) begin
               phase_in = phase_ff + PHASE_BITS'(1);
               count_in = '0;
            end
         end
         PH_FAST: begin
            count_in = count_sight;
            if (qualify) begin
               phase_in = PH_BRAKE_ENTRY;
               cnt_in   = cfg.brake_entry_ticks;
            end
         end
         PH_BRAKE: begin
            count_in = count_sight;
            if (qualify) begin
               phase_in = PH_CORNER_ENTRY;
               cnt_in   = cfg.corner_entry_ticks;
            end
         end
         default: begin
            count_in = count_sight;
            if (qualify) begin
               phase_in = PH_FAST_ENTRY;
               cnt_in   = cfg.fast_entry_ticks;
            end
         end
      endcase
   end

   assign phase_next = phase_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_CORNER;
         count_ff <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   // countdown is loaded before any read
   always_ff @(posedge clock) begin
      if (advance) begin
         cnt_ff <= cnt_in;
      end
   end

   `TPPS_ASSERT_NEXT(a_fast_entry_load,
      advance && phase_ff == PH_CORNER && phase_in == PH_FAST_ENTRY,
      cnt_ff == $past(cfg.fast_entry_ticks))
   `TPPS_ASSERT_NOW(a_entry_exit_expired,
      advance && phase_ff == PH_BRAKE_ENTRY && phase_in == PH_BRAKE,
      cnt_ff == '0)
   `TPPS_ASSERT_NEXT(a_entry_exit_clears,
      advance && phase_in != phase_ff &&
      (phase_ff == PH_CORNER_ENTRY || phase_ff == PH_FAST_ENTRY ||
       phase_ff == PH_BRAKE_ENTRY),
      count_ff == '0)

endmodule
`default_nettype wire

### design/tpps_pd.sv
// PD steering law: negated sum of products, half-up rounding and 16-bit saturation
`default_nettype none
module tpps_pd
   import tpps_pkg::*;
(
   input  wire s1_type                    s1,
   output logic signed [ANGLE_BITS-1:0]   steer_angle
);

   localparam int PP_BITS  = GP_BITS + POS_BITS + 1;
   localparam int PD_BITS  = GD_BITS + POS_BITS + 2;
   localparam int SUM_BITS = GD_BITS + POS_BITS + 3;
   localparam logic signed [SUM_BITS-1:0] ROUND_HALF = SUM_BITS'(128);
   localparam logic signed [SUM_BITS-1:0] SAT_HI = SUM_BITS'(32767);
   localparam logic signed [SUM_BITS-1:0] SAT_LO = -SUM_BITS'(32768);

   logic signed [PP_BITS-1:0]  prod_p;
   logic signed [PD_BITS-1:0]  prod_d;
   logic signed [SUM_BITS-1:0] t;
   logic signed [SUM_BITS-1:0] q;

   always_comb begin
      prod_p = $signed({1'b0, gain_p(s1.phase)}) * s1.pos;
      prod_d = $signed({1'b0, gain_d(s1.phase)}) * s1.diff;
      t      = ROUND_HALF - (SUM_BITS'(prod_p) + SUM_BITS'(prod_d));
      q      = t >>> 8;
      if (q > SAT_HI) begin
         steer_angle = ANGLE_BITS'(SAT_HI);
      end else if (q < SAT_LO) begin
         steer_angle = ANGLE_BITS'(SAT_LO);
      end else begin
         steer_angle = q[ANGLE_BITS-1:0];
      end
   end

endmodule
`default_nettype wire

### design/track_phase_pd_steering_top.sv
// Top level of the track-phase sequencer with PD steering
//
//   channel  direction  transfer when          payload
//   req      in         req_valid & req_ready  req_type: position, mark, enable
//   rsp      out        rsp_valid & rsp_ready  rsp_type: angle, duty, update, phase
//   csr      in         csr_valid & csr_ready  csr_index, csr_data (always ready)
//
// One item per cycle sustained while rsp_ready is high; req passes stage one, then the rsp register.
// The phase update runs at req transfer; the products run in the second stage.
// Stage one and the rsp register each hold one item; req_ready drops only
// when both are full and rsp is stalled.
// Synchronous reset: phase corner, mark count and previous position cleared.
`default_nettype none
`include "track_phase_pd_steering_top_assert.svh"
module track_phase_pd_steering_top
   import tpps_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire req_type                    req_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output rsp_type                         rsp_data,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]   csr_data
);

   cfg_type                     cfg_ff;
   logic signed [POS_BITS-1:0]  prev_ff;
   s1_type                      s1_ff, s1_in;
   logic                        s1_valid_ff, s1_valid_in;
   rsp_type                     rsp_ff, rsp_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        s2_ready;
   logic                        s1_adv;
   logic                        accept;
   logic [PHASE_BITS-1:0]       phase_next;
   logic signed [ANGLE_BITS-1:0] angle;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.qualify_threshold  <= QUALIFY_RESET;
         cfg_ff.fast_entry_ticks   <= FAST_ENTRY_RESET;
         cfg_ff.brake_entry_ticks  <= BRAKE_ENTRY_RESET;
         cfg_ff.corner_entry_ticks <= CORNER_ENTRY_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_QUALIFY:      cfg_ff.qualify_threshold  <= csr_data[SIGHT_BITS-1:0];
            CSR_FAST_ENTRY:   cfg_ff.fast_entry_ticks   <= csr_data[COUNT_BITS-1:0];
            CSR_BRAKE_ENTRY:  cfg_ff.brake_entry_ticks  <= csr_data[COUNT_BITS-1:0];
            CSR_CORNER_ENTRY: cfg_ff.corner_entry_ticks <= csr_data[COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign s2_ready  = !rsp_valid_ff || rsp_ready;
   assign s1_adv    = s1_valid_ff && s2_ready;
   assign req_ready = !s1_valid_ff || s2_ready;
   assign accept    = req_valid && req_ready;

   tpps_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .advance    (accept),
      .road_mark  (req_data.road_mark),
      .cfg        (cfg_ff),
      .phase_next (phase_next)
   );

   always_comb begin
      s1_in.phase  = phase_next;
      s1_in.enable = req_data.remote_enable;
      s1_in.pos    = req_data.line_position;
      s1_in.diff   = (POS_BITS+1)'(req_data.line_position) - (POS_BITS+1)'(prev_ff);
      s1_valid_in  = accept || (s1_valid_ff && !s1_adv);
   end

   tpps_pd u_pd (
      .s1          (s1_ff),
      .steer_angle (angle)
   );

   always_comb begin
      rsp_in.steer_angle  = angle;
      rsp_in.motor_duty   = phase_duty(s1_ff.phase);
      rsp_in.motor_update = s1_ff.enable;
      rsp_in.phase        = s1_ff.phase;
      rsp_valid_in        = s1_adv || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            prev_ff <= req_data.line_position;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (s1_adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `TPPS_ASSERT_NOW(a_duty_matches_phase,
      rsp_valid_ff,
      rsp_ff.motor_duty == phase_duty(rsp_ff.phase))
   `TPPS_ASSERT_NEXT(a_s1_held_on_stall,
      s1_valid_ff && !s1_adv,
      s1_valid_ff && $stable(s1_ff))
   `TPPS_ASSERT_NEXT(a_transfer_fills_s1,
      accept,
      s1_valid_ff && s1_ff.pos == $past(req_data.line_position))

endmodule
`default_nettype wire
